// ===== design/floored_integer_modulo_top_macros.svh =====
// Assertion macros used by the checker in fim_checker.sv.
`ifndef FLOORED_INTEGER_MODULO_TOP_MACROS_SVH
`define FLOORED_INTEGER_MODULO_TOP_MACROS_SVH

// Implication checked at every clock edge outside of reset.
`define FIM_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("floored modulo check failed");

// Implication checked at every clock edge, reset included.
`define FIM_ASSERT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |-> (cons)) \
      else $error("floored modulo check failed");

`endif

// ===== design/fim_pkg.sv =====
package fim_pkg;

   typedef enum logic [1:0] {
      WIDTH_8  = 2'd0,
      WIDTH_16 = 2'd1,
      WIDTH_32 = 2'd2,
      WIDTH_64 = 2'd3
   } fim_width_type;

   localparam logic REG_SIGNED = 1'b0;
   localparam logic REG_WIDTH  = 1'b1;

   typedef struct packed {
      logic valid;
      logic an;
      logic bn;
      logic zero;
   } fim_flags_type;

endpackage

// ===== design/fim_cell.sv =====
module fim_cell #(
   parameter int DATA_WIDTH = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  fim_pkg::fim_flags_type  src_flags,
   input  logic [DATA_WIDTH-1:0]   src_rem,
   input  logic [DATA_WIDTH-1:0]   src_num,
   input  logic [DATA_WIDTH-1:0]   src_den,
   output fim_pkg::fim_flags_type  dst_flags,
   output logic [DATA_WIDTH-1:0]   dst_rem,
   output logic [DATA_WIDTH-1:0]   dst_num,
   output logic [DATA_WIDTH-1:0]   dst_den
);
   import fim_pkg::*;

   fim_flags_type         flags_ff;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] num_ff, num_in;
   logic [DATA_WIDTH-1:0] den_ff;
   logic [DATA_WIDTH:0]   trial;
   logic [DATA_WIDTH:0]   diff;

   // One restoring step: bring down the next dividend bit and subtract if it fits.
   always_comb begin
      trial  = {src_rem, src_num[DATA_WIDTH-1]};
      diff   = trial - {1'b0, src_den};
      rem_in = diff[DATA_WIDTH] ? trial[DATA_WIDTH-1:0] : diff[DATA_WIDTH-1:0];
      num_in = {src_num[DATA_WIDTH-2:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= src_flags;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
      den_ff <= src_den;
   end

   assign dst_flags = flags_ff;
   assign dst_rem   = rem_ff;
   assign dst_num   = num_ff;
   assign dst_den   = den_ff;

endmodule

// ===== design/fim_post.sv =====
module fim_post #(
   parameter int DATA_WIDTH = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  fim_pkg::fim_flags_type  src_flags,
   input  logic [DATA_WIDTH-1:0]   src_rem,
   input  logic [DATA_WIDTH-1:0]   src_den,
   input  fim_pkg::fim_width_type  width_code,
   output logic                    rsp_strobe,
   output logic [63:0]             rsp_remainder
);
   import fim_pkg::*;

   logic                  strobe_ff;
   logic [63:0]           result_ff, result_in;
   logic [DATA_WIDTH-1:0] fixed;
   logic [DATA_WIDTH-1:0] keep;
   logic [6:0]            limit;

   // The sign of the result follows the divisor.
   always_comb begin
      if (src_flags.zero || (src_rem == '0)) begin
         fixed = '0;
      end else if (src_flags.an && src_flags.bn) begin
         fixed = '0 - src_rem;
      end else if (src_flags.an) begin
         fixed = src_den - src_rem;
      end else if (src_flags.bn) begin
         fixed = src_rem - src_den;
      end else begin
         fixed = src_rem;
      end
      case (width_code)
         WIDTH_8:  limit = 7'd8;
         WIDTH_16: limit = 7'd16;
         WIDTH_32: limit = 7'd32;
         default:  limit = 7'd64;
      endcase
      for (int j = 0; j < DATA_WIDTH; j++) begin
         keep[j] = (7'(j) < limit);
      end
      result_in = 64'(fixed & keep);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= src_flags.valid;
      end
      result_ff <= result_in;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_remainder = result_ff;

endmodule

// ===== design/floored_integer_modulo_top.sv =====
// Floored integer modulo, one word accepted in every clock cycle; busy is always low, and
// the receiver cannot stall. Each result appears on rsp_remainder with rsp_strobe high
// once its word has passed an input register that forms the operand magnitudes, a
// chain of DATA_WIDTH divider cells that resolve one quotient bit per cell, and an output
// register that applies the sign fix-up and the output width mask. Results leave in order.
// Configuration registers are to be written by the user through the APB-style port only
// while no word is in flight; the block itself does not enforce this.
module floored_integer_modulo_top #(
   parameter int DATA_WIDTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_dividend,
   input  logic [63:0] req_divisor,
   output logic        rsp_strobe,
   output logic [63:0] rsp_remainder,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import fim_pkg::*;

   logic          signed_ff;
   fim_width_type width_ff;
   logic          write_en;

   fim_flags_type         chain_flags [DATA_WIDTH+1];
   logic [DATA_WIDTH-1:0] chain_rem   [DATA_WIDTH+1];
   logic [DATA_WIDTH-1:0] chain_num   [DATA_WIDTH+1];
   logic [DATA_WIDTH-1:0] chain_den   [DATA_WIDTH+1];

   fim_flags_type         flags_ff, flags_in;
   logic [DATA_WIDTH-1:0] num_ff, num_in;
   logic [DATA_WIDTH-1:0] den_ff, den_in;
   logic [DATA_WIDTH-1:0] a_word;
   logic [DATA_WIDTH-1:0] b_word;

   assign write_en = psel && penable && pwrite && pready;
   assign pready   = 1'b1;
   assign busy     = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         signed_ff <= 1'b1;
         width_ff  <= WIDTH_64;
      end else if (write_en) begin
         if (paddr[2] == REG_SIGNED) begin
            signed_ff <= pwdata[0];
         end else begin
            width_ff <= fim_width_type'(pwdata[1:0]);
         end
      end
   end

   always_comb begin
      if (paddr[2] == REG_WIDTH) begin
         prdata = {30'd0, width_ff};
      end else begin
         prdata = {31'd0, signed_ff};
      end
   end

   always_comb begin
      a_word         = req_dividend[DATA_WIDTH-1:0];
      b_word         = req_divisor[DATA_WIDTH-1:0];
      flags_in.valid = start && !busy;
      flags_in.an    = signed_ff && a_word[DATA_WIDTH-1];
      flags_in.bn    = signed_ff && b_word[DATA_WIDTH-1];
      flags_in.zero  = (b_word == '0);
      num_in         = flags_in.an ? ('0 - a_word) : a_word;
      den_in         = flags_in.bn ? ('0 - b_word) : b_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
   end

   assign chain_flags[0] = flags_ff;
   assign chain_rem[0]   = '0;
   assign chain_num[0]   = num_ff;
   assign chain_den[0]   = den_ff;

   for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
      fim_cell #(
         .DATA_WIDTH(DATA_WIDTH)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .src_flags (chain_flags[i]),
         .src_rem   (chain_rem[i]),
         .src_num   (chain_num[i]),
         .src_den   (chain_den[i]),
         .dst_flags (chain_flags[i+1]),
         .dst_rem   (chain_rem[i+1]),
         .dst_num   (chain_num[i+1]),
         .dst_den   (chain_den[i+1])
      );
   end

   fim_post #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_post (
      .clock         (clock),
      .reset         (reset),
      .src_flags     (chain_flags[DATA_WIDTH]),
      .src_rem       (chain_rem[DATA_WIDTH]),
      .src_den       (chain_den[DATA_WIDTH]),
      .width_code    (width_ff),
      .rsp_strobe    (rsp_strobe),
      .rsp_remainder (rsp_remainder)
   );

endmodule

// ===== design/fim_checker.sv =====
`include "floored_integer_modulo_top_macros.svh"

module fim_checker #(
   parameter int DATA_WIDTH = 64
) (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [63:0] req_divisor,
   input logic        rsp_strobe,
   input logic [63:0] rsp_remainder
);
   localparam int Latency = DATA_WIDTH + 2;

   logic zero_div;
   logic unit_div;

   assign zero_div = (req_divisor[DATA_WIDTH-1:0] == '0);
   assign unit_div = (req_divisor[DATA_WIDTH-1:0] == {{(DATA_WIDTH-1){1'b0}}, 1'b1});

   `FIM_ASSERT_ALWAYS(a_strobe_has_word, rsp_strobe, $past(start && !busy, Latency))
   `FIM_ASSERT_IMP(a_zero_divisor, rsp_strobe && $past(zero_div, Latency), rsp_remainder == '0)
   `FIM_ASSERT_IMP(a_unit_divisor, rsp_strobe && $past(unit_div, Latency), rsp_remainder == '0)
   `FIM_ASSERT_IMP(a_upper_zero, rsp_strobe, (rsp_remainder >> DATA_WIDTH) == 64'd0)

endmodule

bind floored_integer_modulo_top fim_checker #(
   .DATA_WIDTH(DATA_WIDTH)
) u_fim_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_divisor   (req_divisor),
   .rsp_strobe    (rsp_strobe),
   .rsp_remainder (rsp_remainder)
);

// ===== sim/floored_integer_modulo_top_tb.sv =====
module floored_integer_modulo_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fim_pkg::*;

   localparam int DATA_WIDTH = 64;
   localparam int STALL_LIMIT = 4000;
   localparam logic [63:0] MOST_NEGATIVE = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MOST_POSITIVE = 64'h7fff_ffff_ffff_ffff;
   localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;

   typedef struct {
      logic [63:0] dividend;
      logic [63:0] divisor;
   } operand_pair_type;

   typedef struct {
      logic [63:0] dividend;
      logic [63:0] divisor;
      logic [63:0] remainder;
   } remainder_entry_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [63:0] req_dividend;
   logic [63:0] req_divisor;
   logic        rsp_strobe;
   logic [63:0] rsp_remainder;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   operand_pair_type    pending_words[$];
   remainder_entry_type expected_remainders[$];
   logic                signed_setting;
   fim_width_type       width_setting;
   bit                  idling_on;
   int                  gap_left;
   int                  error_count;
   int                  stall_cycles;

   floored_integer_modulo_top #(
      .DATA_WIDTH(DATA_WIDTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_dividend(req_dividend),
      .req_divisor(req_divisor),
      .rsp_strobe(rsp_strobe),
      .rsp_remainder(rsp_remainder),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   function automatic logic [63:0] width_mask(int unsigned w);
      if (w >= 64) begin
         return ALL_ONES;
      end
      return (64'd1 << w) - 64'd1;
   endfunction

   function automatic logic [63:0] datapath_operand(logic [63:0] value, logic is_signed);
      logic [63:0] mask;
      mask = width_mask(DATA_WIDTH);
      value = value & mask;
      if (is_signed && DATA_WIDTH < 64 && value[DATA_WIDTH - 1]) begin
         value = value | ~mask;
      end
      return value;
   endfunction

   function automatic logic [63:0] floored_remainder(logic [63:0] dividend,
                                                     logic [63:0] divisor,
                                                     logic is_signed,
                                                     fim_width_type width_code);
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] mag_a;
      logic [63:0] mag_b;
      logic [63:0] r;
      int unsigned out_width;
      a = datapath_operand(dividend, is_signed);
      b = datapath_operand(divisor, is_signed);
      out_width = 8 << int'(width_code);
      if (out_width > DATA_WIDTH) begin
         out_width = DATA_WIDTH;
      end
      if (!is_signed) begin
         r = (b == 64'd0) ? 64'd0 : a % b;
      end else if (b == 64'd0 || b == ALL_ONES) begin
         r = 64'd0;
      end else begin
         mag_a = a[63] ? 64'd0 - a : a;
         mag_b = b[63] ? 64'd0 - b : b;
         r = mag_a % mag_b;
         if (r != 64'd0) begin
            if (a[63]) begin
               r = 64'd0 - r;
            end
            if (a[63] != b[63]) begin
               r = r + b;
            end
         end
      end
      return r & width_mask(out_width);
   endfunction

   function automatic logic [63:0] random_operand();
      logic [63:0] value;
      case ($urandom_range(0, 7))
         0: value = 64'($urandom_range(0, 20));
         1: value = 64'd0 - 64'($urandom_range(1, 20));
         2: begin
            case ($urandom_range(0, 4))
               0: value = 64'd0;
               1: value = 64'd1;
               2: value = MOST_NEGATIVE;
               3: value = MOST_POSITIVE;
               default: value = ALL_ONES;
            endcase
         end
         3: value = {$urandom, $urandom} >> $urandom_range(1, 63);
         4: value = 64'd0 - ({$urandom, $urandom} >> $urandom_range(1, 63));
         default: value = {$urandom, $urandom};
      endcase
      return value;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch at %0t: %s: got %h, expected %h", $realtime, what, got, want);
      error_count++;
   endtask

   task automatic push_word(logic [63:0] dividend, logic [63:0] divisor);
      operand_pair_type word;
      word.dividend = dividend;
      word.divisor = divisor;
      pending_words.push_back(word);
   endtask

   task automatic wait_for_drain();
      while (pending_words.size() != 0 || start || expected_remainders.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_register(logic index, logic [31:0] value);
      logic [31:0] field_mask;
      field_mask = (index == REG_WIDTH) ? 32'h3 : 32'h1;
      for (int access = 0; access < 2; access++) begin
         @(posedge clock);
         psel <= 1'b1;
         penable <= 1'b0;
         pwrite <= (access == 0);
         paddr <= {index, 2'b00};
         pwdata <= value;
         @(posedge clock);
         penable <= 1'b1;
         @(posedge clock);
         while (!pready) begin
            @(posedge clock);
         end
         if (access == 1 && (prdata & field_mask) != value) begin
            report_mismatch("register read-back", 64'(prdata), 64'(value));
         end
         psel <= 1'b0;
         penable <= 1'b0;
      end
   endtask

   task automatic configure(logic is_signed, fim_width_type width_code, bit with_idling);
      wait_for_drain();
      write_register(REG_SIGNED, 32'(is_signed));
      write_register(REG_WIDTH, 32'(width_code));
      signed_setting = is_signed;
      width_setting = width_code;
      idling_on = with_idling;
   endtask

   task automatic run_random_phase(logic is_signed, fim_width_type width_code,
                                   bit with_idling, int count);
      configure(is_signed, width_code, with_idling);
      repeat (count) begin
         push_word(random_operand(), random_operand());
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left = 0;
      end else begin
         if (start && !busy) begin
            expected_remainders.push_back('{req_dividend, req_divisor,
               floored_remainder(req_dividend, req_divisor, signed_setting, width_setting)});
         end
         if (start && busy) begin
            start <= 1'b1;
         end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_words.size() == 0) begin
            start <= 1'b0;
         end else if (idling_on && $urandom_range(0, 7) == 0) begin
            gap_left = $urandom_range(1, 18) - 1;
            start <= 1'b0;
         end else begin
            operand_pair_type word;
            word = pending_words.pop_front();
            req_dividend <= word.dividend;
            req_divisor <= word.divisor;
            start <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_remainders.size() == 0) begin
            report_mismatch("remainder with nothing outstanding", rsp_remainder, 64'd0);
         end else begin
            remainder_entry_type entry;
            entry = expected_remainders.pop_front();
            if (rsp_remainder !== entry.remainder) begin
               report_mismatch($sformatf("remainder of %h by %h", entry.dividend, entry.divisor),
                               rsp_remainder, entry.remainder);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (psel && penable)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("floored_integer_modulo_top_tb: done, errors");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_dividend = 64'd0;
      req_divisor = 64'd0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = 3'd0;
      pwdata = 32'd0;
      signed_setting = 1'b1;
      width_setting = WIDTH_64;
      idling_on = 1'b1;
      error_count = 0;
      stall_cycles = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      configure(1'b1, WIDTH_64, 1'b1);
      push_word(64'd0, 64'd0);
      push_word(64'd5, 64'd0);
      push_word(64'd7, ALL_ONES);
      push_word(MOST_NEGATIVE, ALL_ONES);
      push_word(MOST_NEGATIVE, 64'd3);
      push_word(MOST_NEGATIVE, MOST_NEGATIVE);
      push_word(64'd0 - 64'd7, 64'd3);
      push_word(64'd7, 64'd0 - 64'd3);
      push_word(64'd0 - 64'd7, 64'd0 - 64'd3);
      push_word(64'd7, 64'd3);
      push_word(64'd0 - 64'd6, 64'd3);
      push_word(64'd6, 64'd0 - 64'd3);
      push_word(MOST_POSITIVE, MOST_NEGATIVE);
      push_word(MOST_NEGATIVE, MOST_POSITIVE);
      push_word(ALL_ONES, MOST_POSITIVE);
      push_word(MOST_POSITIVE, 64'd2);
      push_word(ALL_ONES, ALL_ONES);

      configure(1'b0, WIDTH_64, 1'b1);
      push_word(ALL_ONES, 64'd0);
      push_word(ALL_ONES, ALL_ONES);
      push_word(ALL_ONES, MOST_NEGATIVE);
      push_word(MOST_NEGATIVE, ALL_ONES);
      push_word(64'd7, ALL_ONES);
      push_word(ALL_ONES, 64'd10);

      run_random_phase(1'b1, WIDTH_64, 1'b1, 100);
      run_random_phase(1'b0, WIDTH_8, 1'b1, 100);
      run_random_phase(1'b1, WIDTH_8, 1'b1, 100);
      run_random_phase(1'b0, WIDTH_16, 1'b1, 100);
      run_random_phase(1'b1, WIDTH_16, 1'b1, 100);
      run_random_phase(1'b0, WIDTH_32, 1'b1, 100);
      run_random_phase(1'b1, WIDTH_32, 1'b1, 100);
      run_random_phase(1'b0, WIDTH_64, 1'b0, 60);
      run_random_phase(1'b1, WIDTH_64, 1'b0, 60);

      wait_for_drain();
      repeat (DATA_WIDTH + 8) @(posedge clock);
      if (expected_remainders.size() != 0) begin
         report_mismatch("remainders never delivered", 64'(expected_remainders.size()), 64'd0);
      end
      if (error_count == 0) begin
         $display("floored_integer_modulo_top_tb: done, clean");
      end else begin
         $display("floored_integer_modulo_top_tb: done, errors");
      end
      $finish;
   end

endmodule
